// ===== rtl/gcc_pkg.sv =====
// ---------------------------------------------------------------------------
// gcc_pkg: shared types and constants for the greedy coin change core
// Register map, word widths and the per-stage payload of the divider chain.
// ---------------------------------------------------------------------------
package gcc_pkg;

  localparam int W              = 16;  // width of amounts, coin values, counts
  localparam int COIN_REGS      = 4;   // coin value registers in the map
  localparam int CFG_IDX_W      = 3;
  localparam int DCNT_W         = 3;   // width of denoms_in_use
  localparam int STEP_BITS      = 4;   // quotient bits resolved per stage
  localparam int STAGES_PER_DIV = W / STEP_BITS;

  typedef logic [W-1:0] word_t;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COIN0  = 3'd0,
    REG_COIN1  = 3'd1,
    REG_COIN2  = 3'd2,
    REG_COIN3  = 3'd3,
    REG_DENOMS = 3'd4
  } cfg_reg_t;

  localparam word_t COIN0_RST = 16'd1;
  localparam word_t COIN1_RST = 16'd5;
  localparam word_t COIN2_RST = 16'd10;
  localparam word_t COIN3_RST = 16'd25;
  localparam logic [DCNT_W-1:0] DENOMS_RST = 3'd4;

  // payload carried down the divider chain
  typedef struct packed {
    word_t                        orig;  // dividend of the current lane
    word_t                        rem;   // partial remainder
    word_t                        dvd;   // dividend bits still to shift in
    word_t                        q;     // partial quotient
    logic [COIN_REGS-1:0][W-1:0]  cnt;   // finished coin counts, per lane
    logic [COIN_REGS-1:0][W-1:0]  rmn;   // amount left after each lane
  } div_stage_t;

endpackage

// ===== rtl/gcc_sorter.sv =====
// ---------------------------------------------------------------------------
// gcc_sorter: configuration registers and denomination ordering
// Holds the register map and keeps the denominations in use sorted largest
// first, by odd-even transposition after reset and after every write.
// ---------------------------------------------------------------------------
module gcc_sorter #(
  parameter int LANES = 4,
  parameter int IW    = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [gcc_pkg::W-1:0]               cfg_wdata,
  output logic [LANES-1:0][gcc_pkg::W-1:0]    coin_sorted,
  output logic [IW-1:0]                       last_idx,
  output logic                                busy
);

  localparam int PW = $clog2(LANES + 1);

  logic [gcc_pkg::COIN_REGS-1:0][gcc_pkg::W-1:0] coin_reg;
  logic [gcc_pkg::DCNT_W-1:0]                    dcount;
  logic                                          sort_load;
  logic [PW-1:0]                                 pass_left;
  logic [LANES-1:0][gcc_pkg::W-1:0]              arr_next;
  logic [gcc_pkg::DCNT_W-1:0]                    nsat;

  // denominations in use, saturated to 1..LANES
  always_comb begin
    if (dcount == '0) begin
      nsat = gcc_pkg::DCNT_W'(1);
    end else if (dcount > gcc_pkg::DCNT_W'(LANES)) begin
      nsat = gcc_pkg::DCNT_W'(LANES);
    end else begin
      nsat = dcount;
    end
  end

  // unused slots load as zero so they sink below every used value
  always_comb begin
    arr_next = coin_sorted;
    if (sort_load) begin
      for (int i = 0; i < LANES; i++) begin
        arr_next[i] = (gcc_pkg::DCNT_W'(i) < nsat) ? coin_reg[i] : '0;
      end
    end else if (pass_left != '0) begin
      for (int i = 0; i + 1 < LANES; i++) begin
        if ((i % 2) == int'(pass_left[0])) begin
          if (coin_sorted[i] < coin_sorted[i+1]) begin
            arr_next[i]   = coin_sorted[i+1];
            arr_next[i+1] = coin_sorted[i];
          end
        end
      end
    end
  end

  assign busy = sort_load || (pass_left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_reg[0] <= gcc_pkg::COIN0_RST;
      coin_reg[1] <= gcc_pkg::COIN1_RST;
      coin_reg[2] <= gcc_pkg::COIN2_RST;
      coin_reg[3] <= gcc_pkg::COIN3_RST;
      dcount      <= gcc_pkg::DENOMS_RST;
      sort_load   <= 1'b1;
      pass_left   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (gcc_pkg::cfg_reg_t'(cfg_idx))
          gcc_pkg::REG_COIN0:  coin_reg[0] <= cfg_wdata;
          gcc_pkg::REG_COIN1:  coin_reg[1] <= cfg_wdata;
          gcc_pkg::REG_COIN2:  coin_reg[2] <= cfg_wdata;
          gcc_pkg::REG_COIN3:  coin_reg[3] <= cfg_wdata;
          gcc_pkg::REG_DENOMS: dcount      <= cfg_wdata[gcc_pkg::DCNT_W-1:0];
          default: ;
        endcase
      end
      sort_load <= cfg_we;
      if (sort_load) begin
        pass_left <= PW'(LANES);
      end else if (pass_left != '0) begin
        pass_left <= pass_left - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    coin_sorted <= arr_next;
    if (sort_load) begin
      last_idx <= IW'(nsat - gcc_pkg::DCNT_W'(1));
    end
  end

endmodule

// ===== rtl/gcc_div_stage.sv =====
// ---------------------------------------------------------------------------
// gcc_div_stage: one register stage of the restoring divider chain
// Resolves STEP_BITS quotient bits of one lane; the last stage of a lane
// stores the coin count and the amount left for that denomination.
// ---------------------------------------------------------------------------
module gcc_div_stage #(
  parameter int LANE = 0,
  parameter int SUB  = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vin,
  input  gcc_pkg::div_stage_t     din,
  input  logic [gcc_pkg::W-1:0]   divisor,
  output logic                    vout,
  output gcc_pkg::div_stage_t     dout
);

  localparam bit FIRST = (SUB == 0);
  localparam bit LAST  = (SUB == gcc_pkg::STAGES_PER_DIV - 1);
  localparam int PREV  = (LANE > 0) ? LANE - 1 : 0;

  gcc_pkg::div_stage_t   nx;
  logic [gcc_pkg::W:0]   r17;
  gcc_pkg::word_t        start;

  always_comb begin
    nx    = din;
    start = din.orig;
    r17   = '0;
    if (FIRST) begin
      // lane 0 divides the amount, later lanes what the previous one left
      if (LANE > 0) begin
        start = din.rmn[PREV];
      end
      nx.orig = start;
      nx.rem  = '0;
      nx.dvd  = start;
      nx.q    = '0;
    end
    for (int k = 0; k < gcc_pkg::STEP_BITS; k++) begin
      r17    = {nx.rem, nx.dvd[gcc_pkg::W-1]};
      nx.dvd = {nx.dvd[gcc_pkg::W-2:0], 1'b0};
      if (r17 >= {1'b0, divisor}) begin
        nx.rem = gcc_pkg::W'(r17 - {1'b0, divisor});
        nx.q   = {nx.q[gcc_pkg::W-2:0], 1'b1};
      end else begin
        nx.rem = r17[gcc_pkg::W-1:0];
        nx.q   = {nx.q[gcc_pkg::W-2:0], 1'b0};
      end
    end
    if (LAST) begin
      // zero coin: no coins taken, amount passes through
      nx.cnt[LANE] = (divisor == '0) ? '0      : nx.q;
      nx.rmn[LANE] = (divisor == '0) ? nx.orig : nx.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nx;
    end
  end

endmodule

// ===== rtl/gcc_serialiser.sv =====
// ---------------------------------------------------------------------------
// gcc_serialiser: result buffer and beat sequencer
// Holds one finished amount and issues one beat per denomination in use.
// ---------------------------------------------------------------------------
module gcc_serialiser #(
  parameter int LANES = 4,
  parameter int IW    = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_v,
  input  gcc_pkg::div_stage_t               load_d,
  input  logic [LANES-1:0][gcc_pkg::W-1:0]  coin_sorted,
  input  logic [IW-1:0]                     last_idx,
  input  logic                              stall,
  output logic                              can_load,
  output logic                              valid,
  output logic [gcc_pkg::W-1:0]             coin_value,
  output logic [gcc_pkg::W-1:0]             coin_count,
  output logic [gcc_pkg::W-1:0]             remaining,
  output logic                              failed,
  output logic                              last
);

  localparam int CIW = $clog2(gcc_pkg::COIN_REGS);

  logic                  hold_v;
  gcc_pkg::div_stage_t   hold_d;
  logic [IW-1:0]         idx;
  logic [CIW-1:0]        cidx;
  logic                  beat;
  logic                  fin;

  assign cidx     = CIW'(idx);
  assign valid    = hold_v;
  assign beat     = hold_v && !stall;
  assign fin      = beat && (idx == last_idx);
  assign can_load = !hold_v || fin;

  assign coin_value = coin_sorted[idx];
  assign coin_count = hold_d.cnt[cidx];
  assign remaining  = hold_d.rmn[cidx];
  assign last       = (idx == last_idx);
  assign failed     = last && (remaining != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      idx    <= '0;
    end else if (load_v && can_load) begin
      hold_v <= 1'b1;
      idx    <= '0;
    end else if (fin) begin
      hold_v <= 1'b0;
      idx    <= '0;
    end else if (beat) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_v && can_load) begin
      hold_d <= load_d;
    end
  end

endmodule

// ===== rtl/greedy_coin_change_core.sv =====
// ---------------------------------------------------------------------------
// greedy_coin_change_core: greedy split of an amount over coin denominations
// Input channel takes one amount per beat (in_valid / in_stall); the result
// channel gives one beat per denomination in use, largest value first, with
// the coin value, the count taken, the amount left, last and failed.
// Config port: cfg_we, cfg_idx, cfg_wdata; indexes 0-3 are coin values,
// index 4 is denoms_in_use, other indexes are ignored. Write only when idle.
// Datapath: the chain is a restoring divider per denomination, L of them
// with L = min(NUM_DENOMS, 4), four quotient bits per stage and four stages
// per divider.
// Throughput is set by the result channel, one beat per denomination in use
// (1-4), held while out_stall is high. Amounts enter the chain back to back
// while the result buffer drains.
// Reset: config returns to 1, 5, 10, 25 with four in use; the sorter then
// reorders, and in_stall is high while it does. The same reorder follows
// every config write.
// Receiver stall: the result buffer holds its beat; once the chain backs up
// the whole pipeline freezes and in_stall rises. Nothing is lost or repeated.
// ---------------------------------------------------------------------------
module greedy_coin_change_core #(
  parameter int NUM_DENOMS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // config
  input  logic                              cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [gcc_pkg::W-1:0]             cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gcc_pkg::W-1:0]             amount,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcc_pkg::W-1:0]             coin_value,
  output logic [gcc_pkg::W-1:0]             coin_count,
  output logic [gcc_pkg::W-1:0]             remaining,
  output logic                              failed,
  output logic                              last
);

  localparam int LANES = (NUM_DENOMS < gcc_pkg::COIN_REGS) ? NUM_DENOMS
                                                           : gcc_pkg::COIN_REGS;
  localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NS    = LANES * gcc_pkg::STAGES_PER_DIV;

  logic [LANES-1:0][gcc_pkg::W-1:0]  coin_sorted;
  logic [IW-1:0]                     last_idx;
  logic                              sort_busy;

  logic                              en;        // whole chain advances
  logic                              can_load;  // result buffer free this cycle
  logic                              vin0;
  gcc_pkg::div_stage_t               din0;
  logic [NS-1:0]                     sv;
  gcc_pkg::div_stage_t               sd [NS];

  // Denominations: registers plus the sorted copy the chain divides by
  gcc_sorter #(
    .LANES (LANES),
    .IW    (IW)
  ) u_sorter (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .coin_sorted (coin_sorted),
    .last_idx    (last_idx),
    .busy        (sort_busy)
  );

  // Chain moves unless its tail is full and the buffer cannot take it
  assign en       = !sv[NS-1] || can_load;
  assign in_stall = !en || sort_busy;
  assign vin0     = in_valid && !sort_busy;

  always_comb begin
    din0      = '0;
    din0.orig = amount;
  end

  // Divider chain: lane s/4 divides by the (s/4)-th largest denomination
  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_head
      gcc_div_stage #(
        .LANE (s / gcc_pkg::STAGES_PER_DIV),
        .SUB  (s % gcc_pkg::STAGES_PER_DIV)
      ) u_stage (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .vin     (vin0),
        .din     (din0),
        .divisor (coin_sorted[s / gcc_pkg::STAGES_PER_DIV]),
        .vout    (sv[s]),
        .dout    (sd[s])
      );
    end else begin : g_body
      gcc_div_stage #(
        .LANE (s / gcc_pkg::STAGES_PER_DIV),
        .SUB  (s % gcc_pkg::STAGES_PER_DIV)
      ) u_stage (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .vin     (sv[s-1]),
        .din     (sd[s-1]),
        .divisor (coin_sorted[s / gcc_pkg::STAGES_PER_DIV]),
        .vout    (sv[s]),
        .dout    (sd[s])
      );
    end
  end

  // Result buffer: one beat per denomination in use
  gcc_serialiser #(
    .LANES (LANES),
    .IW    (IW)
  ) u_serialiser (
    .clk         (clk),
    .rst         (rst),
    .load_v      (sv[NS-1]),
    .load_d      (sd[NS-1]),
    .coin_sorted (coin_sorted),
    .last_idx    (last_idx),
    .stall       (out_stall),
    .can_load    (can_load),
    .valid       (out_valid),
    .coin_value  (coin_value),
    .coin_count  (coin_count),
    .remaining   (remaining),
    .failed      (failed),
    .last        (last)
  );

`ifndef ASSERT_OFF
  // an amount never stops part way through its beats
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("result beats of one amount broken up");

  // failure is only ever reported on the final beat
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && failed) |-> last)
    else $error("failed flagged on a beat that is not last");

  // reset empties the result buffer and the sorter blocks input
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_stall))
    else $error("block not quiet after reset");
`endif

endmodule

// ===== verif/gcc_split_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcc_split_checker: result checking for the greedy coin change core
// Mirrors the register writes, works out the greedy split of every accepted
// amount and compares each result beat, field by field, in arrival order.
// ---------------------------------------------------------------------------
module gcc_split_checker #(
  parameter int NUM_DENOMS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gcc_pkg::W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [gcc_pkg::W-1:0]         amount,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gcc_pkg::W-1:0]         coin_value,
  input  logic [gcc_pkg::W-1:0]         coin_count,
  input  logic [gcc_pkg::W-1:0]         remaining,
  input  logic                          failed,
  input  logic                          last,
  output int                            mismatches,
  output int                            beats_owed
);

  typedef struct packed {
    gcc_pkg::word_t value;
    gcc_pkg::word_t count;
    gcc_pkg::word_t left;
    logic           fail;
    logic           fin;
  } coin_beat_t;

  localparam int MAX_USED = (NUM_DENOMS < gcc_pkg::COIN_REGS) ? NUM_DENOMS
                                                              : gcc_pkg::COIN_REGS;

  gcc_pkg::word_t             coin_reg [gcc_pkg::COIN_REGS];
  logic [gcc_pkg::DCNT_W-1:0] denom_reg;
  coin_beat_t                 owed_q[$];
  int                         errs = 0;

  // denominations in use, clamped to 1..MAX_USED
  function automatic int denoms_active();
    int n;
    n = int'(denom_reg);
    if (n < 1) n = 1;
    if (n > MAX_USED) n = MAX_USED;
    return n;
  endfunction

  function automatic void split_amount(gcc_pkg::word_t amt);
    gcc_pkg::word_t vals [gcc_pkg::COIN_REGS];
    gcc_pkg::word_t tmp;
    int unsigned    rest;
    int             n;
    coin_beat_t     b;
    n = denoms_active();
    for (int i = 0; i < gcc_pkg::COIN_REGS; i++) vals[i] = coin_reg[i];
    // largest first; order among equal values is irrelevant
    for (int i = 0; i < n - 1; i++) begin
      for (int j = 0; j < n - 1 - i; j++) begin
        if (vals[j] < vals[j + 1]) begin
          tmp         = vals[j];
          vals[j]     = vals[j + 1];
          vals[j + 1] = tmp;
        end
      end
    end
    rest = amt;
    for (int i = 0; i < n; i++) begin
      b.value = vals[i];
      b.count = '0;
      if (vals[i] != 0) begin
        b.count = gcc_pkg::word_t'(rest / vals[i]);
        rest    = rest % vals[i];
      end
      b.left = gcc_pkg::word_t'(rest);
      b.fin  = (i == n - 1);
      b.fail = b.fin && (rest != 0);
      owed_q.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    coin_beat_t got;
    coin_beat_t want;
    logic       bad;
    if (rst) begin
      coin_reg[0] = gcc_pkg::COIN0_RST;
      coin_reg[1] = gcc_pkg::COIN1_RST;
      coin_reg[2] = gcc_pkg::COIN2_RST;
      coin_reg[3] = gcc_pkg::COIN3_RST;
      denom_reg   = gcc_pkg::DENOMS_RST;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          gcc_pkg::REG_COIN0:  coin_reg[0] = cfg_wdata;
          gcc_pkg::REG_COIN1:  coin_reg[1] = cfg_wdata;
          gcc_pkg::REG_COIN2:  coin_reg[2] = cfg_wdata;
          gcc_pkg::REG_COIN3:  coin_reg[3] = cfg_wdata;
          gcc_pkg::REG_DENOMS: denom_reg   = cfg_wdata[gcc_pkg::DCNT_W-1:0];
          default:    ;
        endcase
      end
      // pop before push so a stray beat never matches a fresh amount
      if (out_valid && !out_stall) begin
        got.value = coin_value;
        got.count = coin_count;
        got.left  = remaining;
        got.fail  = failed;
        got.fin   = last;
        if (owed_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t result beat with nothing owed: value %0d count %0d left %0d",
                     $time, got.value, got.count, got.left);
        end else begin
          want = owed_q.pop_front();
          bad  = (got.value !== want.value) || (got.count !== want.count) ||
                 (got.left !== want.left) || (got.fail !== want.fail) ||
                 (got.fin !== want.fin);
          if (bad) begin
            errs++;
            if (errs <= 10) begin
              $write("%0t mismatch: exp value %0d count %0d left %0d failed %0b last %0b",
                     $time, want.value, want.count, want.left, want.fail, want.fin);
              $display(" / got value %0d count %0d left %0d failed %0b last %0b",
                       got.value, got.count, got.left, got.fail, got.fin);
            end
          end
        end
      end
      if (in_valid && !in_stall) split_amount(amount);
    end
    mismatches <= errs;
    beats_owed <= owed_q.size();
  end

endmodule

// ===== verif/tb_greedy_coin_change_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_greedy_coin_change_core: regression for the greedy coin change core
// Directed amounts over hand-picked coin sets, then random amounts over random
// coin sets under four idling mixes and one long result hold-off. Checking is
// done by gcc_split_checker; this module drives and gives the verdict.
// ---------------------------------------------------------------------------
module tb_greedy_coin_change_core;

  localparam int NUM_DENOMS = 4;
  // longest quiet stretch in a good run is the receiver hold-off plus the
  // post-write sorter pause; random stall runs are much shorter
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  // time for the first result of the last amount, with margin on top
  localparam int SETTLE_CYCLES = 4 * NUM_DENOMS + 24;
  // unmapped config index, writes to it must be dropped
  localparam logic [gcc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [gcc_pkg::W-1:0]         cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [gcc_pkg::W-1:0]         amount    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [gcc_pkg::W-1:0]         coin_value;
  logic [gcc_pkg::W-1:0]         coin_count;
  logic [gcc_pkg::W-1:0]         remaining;
  logic                          failed;
  logic                          last;

  int             mismatches;
  int             beats_owed;
  int             gap_pct   = 0;   // chance the sender idles before a beat, drawn again after each idle
  int             stall_pct = 0;   // chance the receiver stalls in a cycle
  bit             hold_go   = 1'b0;
  gcc_pkg::word_t coin_now [gcc_pkg::COIN_REGS];

  greedy_coin_change_core #(.NUM_DENOMS(NUM_DENOMS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coin_value (coin_value),
    .coin_count (coin_count),
    .remaining  (remaining),
    .failed     (failed),
    .last       (last)
  );

  gcc_split_checker #(.NUM_DENOMS(NUM_DENOMS)) u_split_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coin_value (coin_value),
    .coin_count (coin_count),
    .remaining  (remaining),
    .failed     (failed),
    .last       (last),
    .mismatches (mismatches),
    .beats_owed (beats_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --- config port -------------------------------------------------------
  // leaves cfg_we high so back-to-back writes never drop it mid-step
  task automatic reg_write(logic [gcc_pkg::CFG_IDX_W-1:0] idx, gcc_pkg::word_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx < gcc_pkg::COIN_REGS) coin_now[idx] = data;
    @(posedge clk);
  endtask

  task automatic set_coins(gcc_pkg::word_t c0, gcc_pkg::word_t c1,
                           gcc_pkg::word_t c2, gcc_pkg::word_t c3,
                           logic [gcc_pkg::DCNT_W-1:0] n);
    reg_write(gcc_pkg::REG_COIN0, c0);
    reg_write(gcc_pkg::REG_COIN1, c1);
    reg_write(gcc_pkg::REG_COIN2, c2);
    reg_write(gcc_pkg::REG_COIN3, c3);
    reg_write(gcc_pkg::REG_DENOMS, gcc_pkg::word_t'(n));
    cfg_we <= 1'b0;
  endtask

  // random coin set: small or full-range values, sometimes zero, max, 1 or a repeat
  task automatic random_config();
    gcc_pkg::word_t             v [gcc_pkg::COIN_REGS];
    logic [gcc_pkg::DCNT_W-1:0] n;
    for (int i = 0; i < gcc_pkg::COIN_REGS; i++) begin
      case ($urandom_range(9))
        0:       v[i] = '0;
        1:       v[i] = '1;
        2:       v[i] = 16'd1;
        3, 4, 5: v[i] = gcc_pkg::word_t'($urandom_range(60, 1));
        6:       v[i] = (i == 0) ? gcc_pkg::word_t'(7) : v[$urandom_range(i - 1)];
        default: v[i] = gcc_pkg::word_t'($urandom_range(65535, 1));
      endcase
    end
    if ($urandom_range(3) == 0) n = gcc_pkg::DCNT_W'($urandom_range(7));
    else                        n = gcc_pkg::DCNT_W'($urandom_range(4, 1));
    set_coins(v[0], v[1], v[2], v[3], n);
  endtask

  // --- input channel -----------------------------------------------------
  // returns at the edge where the beat was taken, in_valid still high
  task automatic send_amount(gcc_pkg::word_t a);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    amount   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pauses until every owed result beat is back
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
  endtask

  function automatic gcc_pkg::word_t pick_amount();
    gcc_pkg::word_t c;
    c = coin_now[$urandom_range(gcc_pkg::COIN_REGS - 1)];
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? gcc_pkg::word_t'('1) : gcc_pkg::word_t'('0);
      1, 2:    return gcc_pkg::word_t'($urandom_range(255));
      3, 4:    return gcc_pkg::word_t'(c * $urandom_range(40) + $urandom_range(3));
      default: return gcc_pkg::word_t'($urandom);
    endcase
  endfunction

  // --- receiver: random stalls, or one long hold-off on request ----------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // --- watchdog: cycles with no beat on either channel -------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --- stimulus and verdict ----------------------------------------------
  initial begin
    coin_now[0] = gcc_pkg::COIN0_RST;
    coin_now[1] = gcc_pkg::COIN1_RST;
    coin_now[2] = gcc_pkg::COIN2_RST;
    coin_now[3] = gcc_pkg::COIN3_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset coin set 1/5/10/25: zero, full scale, small values, alternating bit patterns
    send_amount(16'd0);
    send_amount(16'hFFFF);
    send_amount(16'd1);
    send_amount(16'd4);
    send_amount(16'd41);
    send_amount(16'd99);
    send_amount(16'h5555);
    send_amount(16'hAAAA);
    drain_all();

    // equal pair, a zero coin, and a leftover that flags failure
    set_coins(16'd7, 16'd7, 16'd0, 16'd3, 3'd4);
    send_amount(16'd0);
    send_amount(16'd13);
    send_amount(16'd20);
    send_amount(16'hFFFF);
    drain_all();

    // zero denominations in use behaves as one; largest coin value
    set_coins(16'hFFFF, 16'd3, 16'd3, 16'd3, 3'd0);
    send_amount(16'hFFFF);
    send_amount(16'hFFFE);
    drain_all();

    // unmapped index is ignored; too many denominations saturates to four
    reg_write(REG_SPARE, 16'hFFFF);
    set_coins(16'd1, 16'd2, 16'd4, 16'd8, 3'd7);
    send_amount(16'd15);
    send_amount(16'hFFFF);
    drain_all();

    // random part: four idling mixes, four coin sets each
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 61; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      for (int s = 0; s < 4; s++) begin
        random_config();
        repeat (20) send_amount(pick_amount());
        drain_all();
      end
    end

    // result side held off while amounts keep coming: chain fills, input stalls
    gap_pct   = 0;
    stall_pct = 0;
    random_config();
    hold_go = 1'b1;
    repeat (24) send_amount(pick_amount());
    drain_all();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
